// ===== hdl/wmmd_pkg.sv =====
// Shared widths, codes and control structures of the min/max waveform decimator.
`timescale 1ns / 1ps
package wmmd_pkg;

    localparam int MAX_INTERVAL = 4096;

    localparam int SAMPLE_W    = 16;
    localparam int PIXEL_W     = 12;
    localparam int LEN_W       = $clog2(MAX_INTERVAL) + 1;
    localparam int COUNT_W     = LEN_W - 1;
    localparam int HALF_W      = LEN_W - 1;
    localparam int ACC_W       = SAMPLE_W + LEN_W - 1;
    localparam int VPP_W       = 2;
    localparam int OPT_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = LEN_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLES_PER_INTERVAL = 2'd0,
        REG_VALUES_PER_PIXEL     = 2'd1,
        REG_PAIR_OPTION          = 2'd2
    } cfg_index_t;

    localparam logic [VPP_W-1:0] VPP_SINGLE    = 2'd1;
    localparam logic [OPT_W-1:0] OPT_DIRECTION = 2'd0;
    localparam logic [OPT_W-1:0] OPT_MEANS     = 2'd1;
    localparam logic [OPT_W-1:0] OPT_MAX_MIN   = 2'd2;

    localparam logic [LEN_W-1:0] SPI_RESET = 13'd2;
    localparam logic [VPP_W-1:0] VPP_RESET = 2'd2;
    localparam logic [OPT_W-1:0] OPT_RESET = OPT_DIRECTION;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic need_div;
        logic div_done;
    } dp_status_t;

endpackage

// ===== hdl/wmmd_sample_if.sv =====
// Input sample channel: valid/ready handshake with the sample payload.
`timescale 1ns / 1ps
interface wmmd_sample_if;
    import wmmd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [PIXEL_W-1:0]         pixel_index;
    logic                       fresh;

    modport source (output valid, output sample, output pixel_index, output fresh, input ready);
    modport sink   (input valid, input sample, input pixel_index, input fresh, output ready);
endinterface

// ===== hdl/wmmd_pixel_if.sv =====
// Output pixel channel: valid/ready handshake with the envelope pair payload.
`timescale 1ns / 1ps
interface wmmd_pixel_if;
    import wmmd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PIXEL_W-1:0]         out_pixel;
    logic signed [SAMPLE_W-1:0] first_value;
    logic signed [SAMPLE_W-1:0] second_value;

    modport source (output valid, output out_pixel, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input out_pixel, input first_value, input second_value,
                    output ready);
endinterface

// ===== hdl/wmmd_divider.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module wmmd_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [wmmd_pkg::ACC_W-1:0] dividend,
    input  logic [wmmd_pkg::HALF_W-1:0]       divisor,
    output logic                              done,
    output logic signed [wmmd_pkg::ACC_W-1:0] quotient
);
    import wmmd_pkg::*;

    localparam int STEP_W = $clog2(ACC_W);

    logic                    busy_reg,  busy_next;
    logic                    done_reg,  done_next;
    logic [STEP_W-1:0]       step_reg,  step_next;
    logic [HALF_W-1:0]       rem_reg,   rem_next;
    logic [ACC_W-1:0]        quo_reg,   quo_next;
    logic [HALF_W-1:0]       dvs_reg,   dvs_next;
    logic                    neg_reg,   neg_next;
    logic signed [ACC_W-1:0] res_reg,   res_next;

    logic [HALF_W:0]   rem_shift;
    logic [HALF_W:0]   rem_sub;
    logic              fits;
    logic [ACC_W-1:0]  quo_step;
    logic [ACC_W-1:0]  magnitude;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ACC_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        quo_step  = {quo_reg[ACC_W-2:0], fits};
        magnitude = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = magnitude;
            dvs_next  = divisor;
            neg_next  = dividend[ACC_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_sub[HALF_W-1:0] : rem_shift[HALF_W-1:0];
            quo_next  = quo_step;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (dvs_reg == '0)
                    res_next = '0;
                else if (neg_reg)
                    res_next = ~quo_step + 1'b1;
                else
                    res_next = quo_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// ===== hdl/wmmd_datapath.sv =====
// Datapath: configuration registers, interval accumulators, half means and output pair.
`timescale 1ns / 1ps
module wmmd_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [wmmd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [wmmd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [wmmd_pkg::SAMPLE_W-1:0]   sample,
    input  logic [wmmd_pkg::PIXEL_W-1:0]           pixel_index,
    input  logic                                   fresh,
    input  wmmd_pkg::dp_cmd_t                      cmd,
    output wmmd_pkg::dp_status_t                   status,
    output logic [wmmd_pkg::PIXEL_W-1:0]           out_pixel,
    output logic signed [wmmd_pkg::SAMPLE_W-1:0]   first_value,
    output logic signed [wmmd_pkg::SAMPLE_W-1:0]   second_value
);
    import wmmd_pkg::*;

    logic [LEN_W-1:0]          spi_reg;
    logic [VPP_W-1:0]          vpp_reg;
    logic [OPT_W-1:0]          opt_reg;

    logic [COUNT_W-1:0]        count_reg,   count_next;
    logic signed [ACC_W-1:0]   min_reg,     min_next;
    logic signed [ACC_W-1:0]   max_reg,     max_next;
    logic signed [ACC_W-1:0]   sum1_reg,    sum1_next;
    logic signed [ACC_W-1:0]   sum2_reg,    sum2_next;
    logic signed [SAMPLE_W-1:0] first_reg,  first_next;
    logic [PIXEL_W-1:0]        pixel_reg,   pixel_next;
    logic signed [ACC_W-1:0]   hfirst_reg,  hfirst_next;
    logic signed [ACC_W-1:0]   hsecond_reg, hsecond_next;
    logic signed [ACC_W-1:0]   y1_reg,      y1_next;
    logic signed [ACC_W-1:0]   y2_reg,      y2_next;
    logic [PIXEL_W-1:0]        opix_reg,    opix_next;
    logic signed [SAMPLE_W-1:0] ofirst_reg, ofirst_next;
    logic signed [SAMPLE_W-1:0] osecond_reg, osecond_next;

    logic [LEN_W-1:0]          n_len;
    logic [HALF_W-1:0]         n1;
    logic [HALF_W-1:0]         n2;
    logic                      is_first;
    logic [LEN_W-1:0]          count_inc;
    logic signed [ACC_W-1:0]   s_ext;
    logic signed [ACC_W-1:0]   base_min;
    logic signed [ACC_W-1:0]   base_max;
    logic signed [ACC_W-1:0]   sum1_base;
    logic signed [ACC_W-1:0]   sum2_base;
    logic signed [ACC_W-1:0]   pair_a;
    logic signed [ACC_W-1:0]   pair_b;
    logic signed [ACC_W-1:0]   div_dividend;
    logic [HALF_W-1:0]         div_divisor;
    logic                      div_done;
    logic signed [ACC_W-1:0]   div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_reg <= SPI_RESET;
            vpp_reg <= VPP_RESET;
            opt_reg <= OPT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_INTERVAL: spi_reg <= cfg_data;
                REG_VALUES_PER_PIXEL:     vpp_reg <= cfg_data[VPP_W-1:0];
                REG_PAIR_OPTION:          opt_reg <= cfg_data[OPT_W-1:0];
                default:                  spi_reg <= spi_reg;
            endcase
        end
    end

    always_comb
    begin
        if (spi_reg == '0)
            n_len = LEN_W'(1);
        else if (spi_reg > LEN_W'(MAX_INTERVAL))
            n_len = LEN_W'(MAX_INTERVAL);
        else
            n_len = spi_reg;
        n1 = n_len[LEN_W-1:1];
        n2 = HALF_W'(n_len - {1'b0, n1});
    end

    assign is_first  = count_reg == '0;
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign s_ext     = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign base_min  = is_first ? (fresh ? s_ext : hfirst_reg)  : min_reg;
    assign base_max  = is_first ? (fresh ? s_ext : hsecond_reg) : max_reg;
    assign sum1_base = is_first ? '0 : sum1_reg;
    assign sum2_base = is_first ? '0 : sum2_reg;

    assign status.last     = count_inc >= n_len;
    assign status.need_div = (vpp_reg != VPP_SINGLE) && (opt_reg != OPT_MAX_MIN);
    assign status.div_done = div_done;

    assign div_dividend = cmd.div_sel ? sum2_reg : sum1_reg;
    assign div_divisor  = cmd.div_sel ? n2 : n1;

    wmmd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        if (vpp_reg == VPP_SINGLE)
        begin
            pair_a = {{(ACC_W-SAMPLE_W){first_reg[SAMPLE_W-1]}}, first_reg};
            pair_b = '0;
        end
        else
        begin
            unique case (opt_reg)
                OPT_DIRECTION:
                begin
                    pair_a = (y1_reg > y2_reg) ? max_reg : min_reg;
                    pair_b = (y1_reg > y2_reg) ? min_reg : max_reg;
                end
                OPT_MAX_MIN:
                begin
                    pair_a = max_reg;
                    pair_b = min_reg;
                end
                default:
                begin
                    pair_a = y1_reg;
                    pair_b = y2_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        sum1_next    = sum1_reg;
        sum2_next    = sum2_reg;
        first_next   = first_reg;
        pixel_next   = pixel_reg;
        hfirst_next  = hfirst_reg;
        hsecond_next = hsecond_reg;
        y1_next      = y1_reg;
        y2_next      = y2_reg;
        opix_next    = opix_reg;
        ofirst_next  = ofirst_reg;
        osecond_next = osecond_reg;

        if (cmd.accept)
        begin
            if (is_first)
            begin
                first_next = sample;
                pixel_next = pixel_index;
            end
            if (count_reg < n1)
            begin
                sum1_next = sum1_base + s_ext;
                sum2_next = sum2_base;
            end
            else
            begin
                sum1_next = sum1_base;
                sum2_next = sum2_base + s_ext;
            end
            min_next = base_min;
            max_next = base_max;
            if (s_ext < base_min)
                min_next = s_ext;
            else if (s_ext > base_max)
                max_next = s_ext;
            count_next = status.last ? '0 : count_inc[COUNT_W-1:0];
        end

        if (div_done)
        begin
            if (cmd.div_sel)
                y2_next = div_quotient;
            else
                y1_next = div_quotient;
        end

        if (cmd.emit)
        begin
            hfirst_next  = pair_a;
            hsecond_next = pair_b;
            opix_next    = pixel_reg;
            ofirst_next  = pair_a[SAMPLE_W-1:0];
            osecond_next = pair_b[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            hfirst_reg  <= '0;
            hsecond_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            hfirst_reg  <= hfirst_next;
            hsecond_reg <= hsecond_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg     <= min_next;
        max_reg     <= max_next;
        sum1_reg    <= sum1_next;
        sum2_reg    <= sum2_next;
        first_reg   <= first_next;
        pixel_reg   <= pixel_next;
        y1_reg      <= y1_next;
        y2_reg      <= y2_next;
        opix_reg    <= opix_next;
        ofirst_reg  <= ofirst_next;
        osecond_reg <= osecond_next;
    end

    assign out_pixel    = opix_reg;
    assign first_value  = ofirst_reg;
    assign second_value = osecond_reg;

endmodule

// ===== hdl/wmmd_controller.sv =====
// Controller: sequences accumulation, the two half-mean divisions and the output register.
`timescale 1ns / 1ps
module wmmd_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  wmmd_pkg::dp_status_t status,
    output wmmd_pkg::dp_cmd_t    cmd
);
    import wmmd_pkg::*;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_START1,
        S_WAIT1,
        S_START2,
        S_WAIT2,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready      = state_reg == S_ACCUM;
        cmd.accept    = in_valid && in_ready;
        cmd.div_start = (state_reg == S_START1) || (state_reg == S_START2);
        cmd.div_sel   = (state_reg == S_START2) || (state_reg == S_WAIT2);
        cmd.emit      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        unique case (state_reg)
            S_ACCUM:
                if (cmd.accept && status.last)
                    state_next = status.need_div ? S_START1 : S_EMIT;
            S_START1:
                state_next = S_WAIT1;
            S_WAIT1:
                if (status.div_done)
                    state_next = S_START2;
            S_START2:
                state_next = S_WAIT2;
            S_WAIT2:
                if (status.div_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (cmd.emit)
                    state_next = S_ACCUM;
            default:
                state_next = S_ACCUM;
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted pair not presented on the output");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_WAIT1 || state_reg == S_WAIT2))
        else $error("divider finished outside a wait state");

    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.last) |=> !in_ready)
        else $error("input accepted before closing interval was emitted");

    a_div_path_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.last && status.need_div) |=> (state_reg == S_START1))
        else $error("half-mean division skipped");

endmodule

// ===== hdl/waveform_min_max_decimator_unit.sv =====
// Top level of the min/max waveform decimator: channels, configuration port and sub-blocks.
`timescale 1ns / 1ps
// Folds a stream of signed 16-bit samples into one display pair per pixel interval.
// A sample that does not close an interval never holds the input. A closing sample
// with one value per pixel, or with the plain max/min option, holds the input while
// the pair is loaded into the output register. With the ordered min/max or half-mean
// options the two half sums go in turn through one shared divider that yields one
// quotient bit per cycle over 28 bits, and a closing sample holds the input through
// both divisions and the load into the output register. The next interval is taken
// while a finished pair still waits in the output register; a closing sample waits
// longer only if that register is still occupied. Configuration writes are registered,
// never restart an interval, and must be made while no interval is being closed.
module waveform_min_max_decimator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    wmmd_sample_if.sink                       samples,
    wmmd_pixel_if.source                      pixels,
    input  logic                              cfg_write_en,
    input  logic [wmmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wmmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import wmmd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    wmmd_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (pixels.valid),
        .out_ready (pixels.ready),
        .status    (status),
        .cmd       (cmd)
    );

    wmmd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (samples.sample),
        .pixel_index  (samples.pixel_index),
        .fresh        (samples.fresh),
        .cmd          (cmd),
        .status       (status),
        .out_pixel    (pixels.out_pixel),
        .first_value  (pixels.first_value),
        .second_value (pixels.second_value)
    );

endmodule
